// ===== hdl/dual_tone_phase_accumulator_oscillator_unit_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef DUAL_TONE_PHASE_ACCUMULATOR_OSCILLATOR_UNIT_MACROS_SVH
`define DUAL_TONE_PHASE_ACCUMULATOR_OSCILLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define DTPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dtpa_pkg.sv =====
package dtpa_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int TUNE_W     = 32;
  localparam int AMP_W      = 14;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(9830);

  // quarter-wave polynomial coefficients, Q16
  localparam logic [17:0] POLY_A = 18'd205887;
  localparam logic [16:0] POLY_B = 17'd84095;
  localparam logic [13:0] POLY_C = 14'd9279;

  // sine unit pipeline depth and output queue depth
  localparam int SINE_LAT   = 6;
  localparam int FIFO_DEPTH = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TUNE_ONE = 2'd0,
    CFG_TUNE_TWO = 2'd1,
    CFG_AMP      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic vld;
    logic en;
    logic last;
  } tag_t;

endpackage

// ===== hdl/dual_tone_phase_accumulator_oscillator_unit.sv =====
// An accepted input word passes through the sine pipelines and the output queue to out_tdata.
// Throughput: one word per clock while in_tready is high, set by the phase RAM read-modify-write with bypass.
// A 16-entry output queue with credits lets input run while output is stalled.
// Reset (rst_n low, synchronous): phases read as zero, tuning words zero, amplitude 9830,
// pipeline and output queue empty. No clearing pass is needed.
module dual_tone_phase_accumulator_oscillator_unit import dtpa_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,  // [0] tone_enable
  input  logic                                 in_tlast,  // block_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata, // audio_sample, zero padded
  output logic                                 out_tlast, // block_end_out
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_ADDR_W-1:0]                cfg_addr,
  input  logic [CFG_DATA_W-1:0]                cfg_data
);

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int FAW   = $clog2(FIFO_DEPTH);
  localparam int CW    = $clog2(FIFO_DEPTH + 1);
  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                   last;
    logic [SAMPLE_BITS-1:0] sample;
  } fifo_word_t;

  // configuration
  logic [TUNE_W-1:0] tw1_r, tw2_r;
  logic [AMP_W-1:0]  amp_r;

  // phase store with bypass
  logic                    in_acc, out_acc;
  logic [2*PHASE_BITS-1:0] ram_rdata, ph_wdata;
  logic [2*PHASE_BITS-1:0] byp_data_r;
  logic                    byp_vld_r, mem_vld_r;
  logic [2*PHASE_BITS-1:0] ph_cur;
  logic [PHASE_BITS-1:0]   ph1, ph2;

  logic signed [SAMPLE_BITS-1:0] tone1, tone2;
  tag_t tag_r [SINE_LAT];

  logic signed [SAMPLE_BITS:0] sum;
  logic [SAMPLE_BITS-1:0]      sat, res;

  fifo_word_t        fifo_r [FIFO_DEPTH];
  logic [FAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     fill_r, fill_nxt, cred_r, cred_nxt;
  logic              fifo_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw1_r <= '0;
      tw2_r <= '0;
      amp_r <= AMP_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_TUNE_ONE: tw1_r <= cfg_data[TUNE_W-1:0];
        CFG_TUNE_TWO: tw2_r <= cfg_data[TUNE_W-1:0];
        CFG_AMP:      amp_r <= cfg_data[AMP_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_tready = (cred_r != CW'(FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // the word written last cycle is not yet in the RAM read data
  assign ph_cur = byp_vld_r ? byp_data_r : (mem_vld_r ? ram_rdata : '0);
  assign ph1    = ph_cur[PHASE_BITS-1:0];
  assign ph2    = ph_cur[2*PHASE_BITS-1:PHASE_BITS];
  assign ph_wdata = in_tdata[0] ? {ph2 + PHASE_BITS'(tw2_r), ph1 + PHASE_BITS'(tw1_r)} : '0;

  dtpa_ram #(
    .WIDTH(2*PHASE_BITS),
    .DEPTH(1)
  ) u_phase_ram (
    .clk  (clk),
    .we   (in_acc),
    .waddr(1'b0),
    .wdata(ph_wdata),
    .raddr(1'b0),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
      mem_vld_r <= 1'b0;
    end else begin
      byp_vld_r <= in_acc;
      if (in_acc) begin
        mem_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_data_r <= ph_wdata;
    end
  end

  dtpa_sine #(
    .PHASE_BITS(PHASE_BITS), .TABLE_ADDR_BITS(TABLE_ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sine_one (
    .clk(clk), .phase_i(ph1), .amp_i(amp_r), .tone_o(tone1)
  );

  dtpa_sine #(
    .PHASE_BITS(PHASE_BITS), .TABLE_ADDR_BITS(TABLE_ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sine_two (
    .clk(clk), .phase_i(ph2), .amp_i(amp_r), .tone_o(tone2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SINE_LAT; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      tag_r[0] <= '{vld: in_acc, en: in_tdata[0], last: in_tlast};
      for (int i = 1; i < SINE_LAT; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  // sum and clamp
  assign sum = {tone1[SAMPLE_BITS-1], tone1} + {tone2[SAMPLE_BITS-1], tone2};
  assign sat = (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1])
             ? (sum[SAMPLE_BITS] ? S_MIN : S_MAX) : sum[SAMPLE_BITS-1:0];
  assign res = tag_r[SINE_LAT-1].en ? sat : '0;
  assign fifo_we = tag_r[SINE_LAT-1].vld;

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_r[wr_ptr_r] <= '{last: tag_r[SINE_LAT-1].last, sample: res};
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    cred_nxt = cred_r;
    if (fifo_we) begin
      fill_nxt = fill_nxt + 1'b1;
    end
    if (out_acc) begin
      fill_nxt = fill_nxt - 1'b1;
      cred_nxt = cred_nxt - 1'b1;
    end
    if (in_acc) begin
      cred_nxt = cred_nxt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      cred_r   <= '0;
    end else begin
      if (fifo_we) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
      cred_r <= cred_nxt;
    end
  end

  assign out_tvalid = (fill_r != '0);
  assign out_tdata  = OUT_W'(fifo_r[rd_ptr_r].sample);
  assign out_tlast  = fifo_r[rd_ptr_r].last;

endmodule

// ===== hdl/dtpa_ram.sv =====
module dtpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dtpa_sine.sv =====
module dtpa_sine import dtpa_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic [PHASE_BITS-1:0]         phase_i,
  input  logic [AMP_W-1:0]              amp_i,
  output logic signed [SAMPLE_BITS-1:0] tone_o
);

  localparam int RW  = TABLE_ADDR_BITS - 2;
  localparam int ZSH = 16 - RW;
  localparam int SHL = (SAMPLE_BITS >= 17) ? SAMPLE_BITS - 17 : 0;
  localparam int SHR = (SAMPLE_BITS < 17) ? 17 - SAMPLE_BITS : 0;
  localparam int YW  = 18 + SHL;
  localparam int MW  = SAMPLE_BITS - 1;
  localparam int PW  = MW + AMP_W;
  localparam logic [MW-1:0] MAG_MAX = {MW{1'b1}};

  logic [1:0]    quad;
  logic [RW-1:0] frac;
  logic [16:0]   z_raw, z_nxt;

  logic [16:0] z1_r, z2_r, z3_r, z4_r;
  logic [1:0]  q1_r, q2_r, q3_r, q4_r;
  logic        neg_r;

  logic [33:0] zz;
  logic [16:0] zsq_r, zsq3_r;
  logic [30:0] cz;
  logic [16:0] inner_nxt, inner_r;
  logic [33:0] zi;
  logic [17:0] outer_nxt, outer_r;
  logic [34:0] zo;
  logic [17:0] y;
  logic [YW-1:0] ys;
  logic [MW-1:0] mag_nxt, mag_r;
  logic [PW-1:0] prod;
  logic [MW-1:0] scaled;
  logic signed [SAMPLE_BITS-1:0] tone_nxt;

  // quadrant and position within it; odd quadrants run backwards
  assign quad  = phase_i[PHASE_BITS-1 -: 2];
  assign frac  = phase_i[PHASE_BITS-3 -: RW];
  assign z_raw = 17'(frac) << ZSH;
  assign z_nxt = quad[0] ? (17'h10000 - z_raw) : z_raw;

  assign zz        = 34'(z1_r) * 34'(z1_r);
  assign cz        = 31'(zsq_r) * 31'(POLY_C);
  assign inner_nxt = POLY_B - 17'(cz[30:16]);
  assign zi        = 34'(zsq3_r) * 34'(inner_r);
  assign outer_nxt = POLY_A - zi[33:16];
  assign zo        = 35'(z4_r) * 35'(outer_r);
  assign y         = zo[34:17];
  assign ys        = (YW'(y) << SHL) >> SHR;
  assign mag_nxt   = (ys > YW'(MAG_MAX)) ? MAG_MAX : MW'(ys);

  assign prod     = PW'(mag_r) * PW'(amp_i);
  assign scaled   = MW'(prod >> 15);
  assign tone_nxt = neg_r ? -$signed(SAMPLE_BITS'(scaled)) : $signed(SAMPLE_BITS'(scaled));

  always_ff @(posedge clk) begin
    z1_r    <= z_nxt;
    q1_r    <= quad;
    zsq_r   <= zz[32:16];
    z2_r    <= z1_r;
    q2_r    <= q1_r;
    inner_r <= inner_nxt;
    zsq3_r  <= zsq_r;
    z3_r    <= z2_r;
    q3_r    <= q2_r;
    outer_r <= outer_nxt;
    z4_r    <= z3_r;
    q4_r    <= q3_r;
    mag_r   <= mag_nxt;
    neg_r   <= q4_r[1];
    tone_o  <= tone_nxt;
  end

endmodule

// ===== hdl/dtpa_checker.sv =====
`include "dual_tone_phase_accumulator_oscillator_unit_macros.svh"

module dtpa_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  input logic                             out_tlast
);

  `DTPA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result word dropped while stalled")
  `DTPA_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "stalled result word changed")
  `DTPA_ASSERT_IMP(a_full_backlog, !in_tready, out_tvalid, "input held off with no result queued")
  `DTPA_ASSERT_IMP(a_reset_empty, $past(!rst_n), !out_tvalid, "result word shown right after reset")

endmodule

bind dual_tone_phase_accumulator_oscillator_unit dtpa_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_dtpa_checker (.*);

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtpa_pkg::*;

  localparam int SMP_W     = SAMPLE_BITS_DEF;
  localparam int OUT_W     = ((SMP_W + 7) / 8) * 8;
  localparam int DRAIN_CYC = SINE_LAT + 4;
  localparam int CYCLE_CAP = 200000;
  localparam int HOLD_CYC  = 200;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_t          reg_idx;
    logic [31:0]       wdata;
    logic              en;
    logic              blk;
    logic              known;
    logic signed [15:0] want;
  } plan_row_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             blk;
  } frame_res_t;

  // directed opening: quarter-turn steps land on exact peaks and zeros
  localparam plan_row_t PLAN [33] = '{
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b0, 1'b0, 1'b1,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b1, 1'b1,  16'sd0},
    '{ROW_WRITE, CFG_TUNE_ONE, 32'h4000_0000, 1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_WRITE, CFG_TUNE_TWO, 32'h4000_0000, 1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b0, 1'b0, 1'b1,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b1, 1'b1,  16'sd19658},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1, -16'sd19658},
    '{ROW_WRITE, CFG_AMP,      32'd16383,     1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1,  16'sd32764},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b1, 1'b1,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1, -16'sd32764},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1,  16'sd0},
    // disabled word clears phases, so the next one is back at zero
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b0, 1'b1, 1'b1,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1,  16'sd0},
    '{ROW_WRITE, CFG_AMP,      32'd0,         1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b1,  16'sd0},
    '{ROW_WRITE, CFG_TUNE_ONE, 32'h8000_0000, 1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_WRITE, CFG_TUNE_TWO, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_WRITE, CFG_AMP,      32'd16383,     1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b1, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b0,  16'sd0},
    '{ROW_WRITE, CFG_TUNE_ONE, 32'h0123_4567, 1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_WRITE, CFG_TUNE_TWO, 32'h0000_0001, 1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_WRITE, CFG_AMP,      32'd9830,      1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b1, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b0, 1'b0, 1'b0,  16'sd0},
    '{ROW_FRAME, CFG_TUNE_ONE, 32'h0,         1'b1, 1'b0, 1'b0,  16'sd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;   // [0] tone_enable, [7:1] zero
  logic                  in_tlast = 1'b0;   // block_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;         // [SMP_W-1:0] audio_sample, rest zero
  logic                  out_tlast;         // block_end_out
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_TUNE_ONE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the oscillator state and registers
  logic [31:0]    tone1_phase, tone2_phase;
  logic [31:0]    step_one, step_two;
  logic [AMP_W-1:0] gain;

  frame_res_t pending_frames[$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         sender_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_asked = 0;
  int         hold_served = 0;
  int         hold_left = 0;

  dual_tone_phase_accumulator_oscillator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // quarter-wave polynomial sine of the top phase bits, scaled by the gain
  function automatic int scaled_tone(logic [31:0] phase);
    logic [9:0]      addr;
    longint unsigned z, z2, inner, outer, y, mag, prod;
    addr  = phase[31:22];
    z     = longint'(addr[7:0]) << 8;
    if (addr[8]) z = 65536 - z;
    z2    = (z * z) >> 16;
    inner = POLY_B - ((z2 * POLY_C) >> 16);
    outer = POLY_A - ((z2 * inner) >> 16);
    y     = (z * outer) >> 17;
    mag   = y >> (17 - SMP_W);
    if (mag > 32767) mag = 32767;
    prod  = (mag * gain) >> 15;
    return addr[9] ? -int'(prod) : int'(prod);
  endfunction

  function automatic frame_res_t synth_frame(logic en, logic blk);
    frame_res_t r;
    int         total;
    total = 0;
    if (en) begin
      total = scaled_tone(tone1_phase) + scaled_tone(tone2_phase);
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      tone1_phase = tone1_phase + step_one;
      tone2_phase = tone2_phase + step_two;
    end else begin
      tone1_phase = '0;
      tone2_phase = '0;
    end
    r.sample = SMP_W'(total);
    r.blk    = blk;
    return r;
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TUNE_ONE: step_one = val;
      CFG_TUNE_TWO: step_two = val;
      CFG_AMP:      gain = val[AMP_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic push_frame(logic en, logic blk, logic known, logic signed [15:0] want);
    frame_res_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, en};
    in_tlast  <= blk;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = synth_frame(en, blk);
    if (known) r.sample = want;
    pending_frames.push_back(r);
  endtask

  function automatic logic [31:0] pick_tuning();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      3:       return $urandom_range(32'h0010_0000, 1);
      default: return $urandom_range(32'h8000_0000, 0);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'd16383;
      default: return $urandom_range(16383, 0);
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_left == 0 && hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, got sample %0d last %0b", $time,
                 $signed(out_tdata[SMP_W-1:0]), out_tlast);
      end else begin
        exp_r = pending_frames.pop_front();
        if (out_tdata !== OUT_W'(exp_r.sample)) begin
          fail_count++;
          $display("%0t: sample mismatch, expected %0d, got %0d", $time,
                   $signed(exp_r.sample), $signed(out_tdata[SMP_W-1:0]));
        end
        if (out_tlast !== exp_r.blk) begin
          fail_count++;
          $display("%0t: block end mismatch, expected %0b, got %0b", $time,
                   exp_r.blk, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("dual_tone_phase_accumulator_oscillator_unit test failed");
      $finish;
    end
  end

  initial begin
    tone1_phase = '0;
    tone2_phase = '0;
    step_one    = '0;
    step_two    = '0;
    gain        = AMP_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_WRITE)
        write_reg(PLAN[i].reg_idx, PLAN[i].wdata);
      else
        push_frame(PLAN[i].en, PLAN[i].blk, PLAN[i].known, PLAN[i].want);
    end

    // idling modes: none, sender only, receiver only, both
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 84; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 84; end
        default: begin sender_idle_pct = 29; stall_pct = 29; end
      endcase
      for (int half = 0; half < 2; half++) begin
        write_reg(CFG_TUNE_ONE, pick_tuning());
        write_reg(CFG_TUNE_TWO, pick_tuning());
        write_reg(CFG_AMP, pick_gain());
        for (int n = 0; n < 128; n++) begin
          if (mode == 0 && half == 0 && n == 40) hold_asked++;
          if (mode == 1 && half == 1 && n == 64) wait_drained();
          push_frame($urandom_range(99) < 92, $urandom_range(7) == 0, 1'b0, 16'sd0);
        end
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("dual_tone_phase_accumulator_oscillator_unit test passed");
    else
      $display("dual_tone_phase_accumulator_oscillator_unit test failed");
    $finish;
  end

endmodule
